// ===== sv/pfmt_pkg.sv =====
// ---------------------------------------------------------------------------
// pfmt_pkg
// types and constants shared by the integer field formatter
// ---------------------------------------------------------------------------
`default_nettype none
package pfmt_pkg;

	localparam logic [2:0] CONV_SDEC = 3'd0;
	localparam logic [2:0] CONV_UDEC = 3'd1;
	localparam logic [2:0] CONV_OCT  = 3'd2;
	localparam logic [2:0] CONV_HEXL = 3'd3;
	localparam logic [2:0] CONV_HEXU = 3'd4;
	localparam logic [2:0] CONV_PTR  = 3'd5;

	localparam int unsigned MAX_OUT    = 64;
	localparam int unsigned NDIG       = 22;
	localparam int unsigned PTR_PREC   = 16;

	typedef struct packed {
		logic [2:0]  conv_type;
		logic [1:0]  size_code;
		logic        left_align;
		logic        force_plus;
		logic        zero_pad;
		logic        blank_sign;
		logic        alt_form;
		logic [6:0]  field_width;
		logic        precision_given;
		logic [5:0]  digit_precision;
		logic [63:0] value;
	} pfmt_in_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} pfmt_out_t;

	// classified item handed from front to back
	typedef enum logic [1:0] {BASE_DEC, BASE_OCT, BASE_HEX} base_t;

	typedef struct packed {
		logic [63:0] mag;
		base_t       base;
		logic        upper;
		logic        left;
		logic        zpad;
		logic [1:0]  plen;
		logic [7:0]  pre0;
		logic [7:0]  pre1;
		logic [6:0]  width;
		logic [5:0]  prec;
		logic        oct_alt;
	} pfmt_job_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_BCD, ST_CONV, ST_SIZE, ST_EMIT
	} pfmt_state_t;

	typedef enum logic [2:0] {
		SEG_LPAD, SEG_PRE, SEG_ZPAD, SEG_ZERO, SEG_DIG, SEG_RPAD, SEG_DONE
	} pfmt_seg_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
		logic [7:0] r;
		if (d < 4'd10) r = 8'h30 + {4'd0, d};
		else if (upper) r = 8'h37 + {4'd0, d};
		else r = 8'h57 + {4'd0, d};
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/pfmt_if.sv =====
// ---------------------------------------------------------------------------
// pfmt_if
// valid/ready channel carrying one payload
// ---------------------------------------------------------------------------
`default_nettype none
interface pfmt_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/pfmt_front.sv =====
// ---------------------------------------------------------------------------
// pfmt_front
// accepts an item, sizes and signs the value, builds the prefix
// ---------------------------------------------------------------------------
`default_nettype none
module pfmt_front #(
	parameter int unsigned MAX_WIDTH     = 64,
	parameter int unsigned MAX_PRECISION = 40
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pfmt_pkg::pfmt_in_t  in_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output pfmt_pkg::pfmt_job_t      job,
	output logic                     job_valid,
	input  wire logic                job_ready
);
	import pfmt_pkg::*;

	logic [2:0]  conv;
	logic [63:0] mask, mag_u, mag;
	logic        neg, left, plus, blank;
	logic [6:0]  wid;
	logic [5:0]  prec;
	pfmt_job_t   j;
	logic        signbit;

	always_comb begin
		conv = (in_data.conv_type > CONV_PTR) ? CONV_UDEC : in_data.conv_type;
		left = in_data.left_align;
		plus = in_data.force_plus;
		blank = in_data.blank_sign & ~plus;
		wid = (in_data.field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : in_data.field_width;
		if (conv == CONV_PTR) begin
			mask = '1;
			prec = 6'(PTR_PREC);
			signbit = in_data.value[63];
		end else begin
			case (in_data.size_code)
				2'd0: begin mask = 64'hFF; signbit = in_data.value[7]; end
				2'd1: begin mask = 64'hFFFF; signbit = in_data.value[15]; end
				2'd2: begin mask = 64'hFFFF_FFFF; signbit = in_data.value[31]; end
				default: begin mask = '1; signbit = in_data.value[63]; end
			endcase
			if (!in_data.precision_given) prec = 6'd1;
			else if (in_data.digit_precision > 6'(MAX_PRECISION)) prec = 6'(MAX_PRECISION);
			else prec = in_data.digit_precision;
		end
		mag_u = in_data.value & mask;
		neg = (conv == CONV_SDEC) && signbit;
		mag = neg ? ((~mag_u + 64'd1) & mask) : mag_u;
		j = '0;
		j.mag = mag;
		j.left = left;
		j.zpad = in_data.zero_pad & ~left;
		j.width = wid;
		j.prec = prec;
		j.upper = (conv != CONV_HEXL);
		j.pre0 = 8'h30;
		j.pre1 = (conv == CONV_HEXL) ? 8'h78 : 8'h58;
		case (conv)
			CONV_SDEC, CONV_UDEC: j.base = BASE_DEC;
			CONV_OCT: j.base = BASE_OCT;
			default: j.base = BASE_HEX;
		endcase
		if (conv == CONV_SDEC) begin
			j.plen = (neg | plus | blank) ? 2'd1 : 2'd0;
			j.pre0 = neg ? 8'h2D : (plus ? 8'h2B : 8'h20);
		end else if (in_data.alt_form && conv == CONV_OCT) begin
			j.oct_alt = 1'b1; // decided once digit count is known
		end else if (in_data.alt_form && conv >= CONV_HEXL && mag != 64'd0) begin
			j.plen = 2'd2;
		end
	end

	// single-entry output register towards the queue
	assign in_ready = ~job_valid | job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid <= 1'b0;
		end else if (in_ready) begin
			job_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) job <= j;
	end
endmodule
`default_nettype wire

// ===== sv/pfmt_fifo.sv =====
// ---------------------------------------------------------------------------
// pfmt_fifo
// two-entry queue between front and back
// ---------------------------------------------------------------------------
`default_nettype none
module pfmt_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pfmt_pkg::pfmt_job_t  wr_data,
	input  wire logic                 wr_valid,
	output logic                      wr_ready,
	output pfmt_pkg::pfmt_job_t       rd_data,
	output logic                      rd_valid,
	input  wire logic                 rd_ready
);
	import pfmt_pkg::*;

	pfmt_job_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid & wr_ready;
	assign rd = rd_valid & rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

// ===== sv/pfmt_back.sv =====
// ---------------------------------------------------------------------------
// pfmt_back
// converts the magnitude to digits and streams the field
// ---------------------------------------------------------------------------
`default_nettype none
module pfmt_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pfmt_pkg::pfmt_job_t  job,
	input  wire logic                 job_valid,
	output logic                      job_ready,
	output pfmt_pkg::pfmt_out_t       out_data,
	output logic                      out_valid,
	input  wire logic                 out_ready
);
	import pfmt_pkg::*;

	localparam int unsigned DW   = $clog2(NDIG + 1);
	localparam int unsigned NBCD = 20;

	pfmt_state_t state_q, state_d;
	pfmt_job_t   job_q;
	logic [79:0] rem_q;
	logic [79:0] bcd_q;
	logic [5:0]  bit_q;
	logic [3:0]  dig_q [NDIG];
	logic [DW-1:0] nd_q;
	logic [6:0]  zeros_q, pad_q, cnt_q;
	logic [1:0]  plen_q;
	pfmt_seg_t   seg_q;
	logic [6:0]  idx_q;

	// decimal: shift-and-add-3 to bcd, digits then peeled as nibbles
	logic [79:0] bcd_adj, bcd_nx;
	always_comb begin
		for (int k = 0; k < NBCD; k++) begin
			bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
				: bcd_q[4*k +: 4];
		end
		bcd_nx = {bcd_adj[78:0], rem_q[63]};
	end

	// one digit per cycle: octal by 3-bit shift, hex and bcd by 4-bit shift
	logic [79:0] q;
	logic [3:0]  d;
	always_comb begin
		if (job_q.base == BASE_OCT) begin
			q = rem_q >> 3;
			d = {1'b0, rem_q[2:0]};
		end else begin
			q = rem_q >> 4;
			d = rem_q[3:0];
		end
	end

	// sizing of the field once digits are known
	logic [6:0] zeros_c, plen_c, flen_c, pad_c;
	always_comb begin
		zeros_c = (7'(job_q.prec) > 7'(nd_q)) ? 7'(job_q.prec) - 7'(nd_q) : 7'd0;
		plen_c = {5'd0, job_q.plen};
		if (job_q.oct_alt && zeros_c == 7'd0) plen_c = 7'd1;
		flen_c = plen_c + zeros_c + 7'(nd_q);
		pad_c = (job_q.width > flen_c) ? job_q.width - flen_c : 7'd0;
	end

	// segment walker
	logic       emit;
	logic [7:0] ch;
	logic [6:0] seg_len;
	pfmt_seg_t  seg_nx;
	logic [DW-1:0] dsel;
	always_comb begin
		case (seg_q)
			SEG_LPAD: seg_len = (!job_q.left && !job_q.zpad) ? pad_q : 7'd0;
			SEG_PRE:  seg_len = {5'd0, plen_q};
			SEG_ZPAD: seg_len = job_q.zpad ? pad_q : 7'd0;
			SEG_ZERO: seg_len = zeros_q;
			SEG_DIG:  seg_len = 7'(nd_q);
			SEG_RPAD: seg_len = job_q.left ? pad_q : 7'd0;
			default:  seg_len = 7'd0;
		endcase
		seg_nx = (seg_q == SEG_DONE) ? SEG_DONE : pfmt_seg_t'(seg_q + 3'd1);
		dsel = DW'(7'(nd_q) - 7'd1 - idx_q);
		case (seg_q)
			SEG_LPAD, SEG_RPAD: ch = 8'h20;
			SEG_PRE: ch = (idx_q == 7'd0) ? job_q.pre0 : job_q.pre1;
			SEG_DIG: ch = hex_char(dig_q[dsel], job_q.upper);
			default: ch = 8'h30;
		endcase
		emit = (state_q == ST_EMIT) && (seg_q != SEG_DONE) && (idx_q < seg_len)
			&& (cnt_q < 7'(MAX_OUT));
	end

	logic outreg_free;
	logic fire;
	assign outreg_free = ~out_valid | out_ready;
	assign fire = emit & outreg_free;
	assign job_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (job_valid) state_d = (job.base == BASE_DEC) ? ST_BCD : ST_CONV;
			ST_BCD:  if (bit_q == 6'd63) state_d = ST_CONV;
			ST_CONV: if (rem_q == 80'd0) state_d = ST_SIZE;
			ST_SIZE: state_d = ST_EMIT;
			ST_EMIT: if (seg_q == SEG_DONE) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q <= SEG_LPAD;
			idx_q <= 7'd0;
			cnt_q <= 7'd0;
			nd_q <= '0;
			bit_q <= 6'd0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					nd_q <= '0;
					cnt_q <= 7'd0;
					seg_q <= SEG_LPAD;
					idx_q <= 7'd0;
					bit_q <= 6'd0;
				end
				ST_BCD: bit_q <= bit_q + 6'd1;
				ST_CONV: if (rem_q != 80'd0) nd_q <= nd_q + DW'(1);
				ST_EMIT: begin
					if (emit) begin
						if (outreg_free) begin
							cnt_q <= cnt_q + 7'd1;
							if (idx_q + 7'd1 >= seg_len) begin
								idx_q <= 7'd0;
								seg_q <= seg_nx;
							end else begin
								idx_q <= idx_q + 7'd1;
							end
						end
					end else if (seg_q != SEG_DONE) begin
						// empty segment, or output full at the length limit
						if (cnt_q >= 7'(MAX_OUT)) seg_q <= SEG_DONE;
						else begin
							idx_q <= 7'd0;
							seg_q <= seg_nx;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// last flag: no further character follows in this field
	logic last_c;
	always_comb begin
		last_c = (cnt_q + 7'd1 == 7'(MAX_OUT))
			|| (cnt_q + 7'd1 == pad_q + {5'd0, plen_q} + zeros_q + 7'(nd_q));
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			job_q <= job;
			rem_q <= {16'd0, job.mag};
			bcd_q <= '0;
		end
		if (state_q == ST_BCD) begin
			bcd_q <= bcd_nx;
			rem_q <= (bit_q == 6'd63) ? bcd_nx : {rem_q[78:0], 1'b0};
		end
		if (state_q == ST_CONV && rem_q != 80'd0) begin
			dig_q[nd_q[$clog2(NDIG)-1:0]] <= d;
			rem_q <= q;
		end
		if (state_q == ST_SIZE) begin
			zeros_q <= zeros_c;
			pad_q <= pad_c;
			plen_q <= plen_c[1:0];
		end
		if (fire) begin
			out_data.character <= ch;
			out_data.last <= last_c;
		end
	end
endmodule
`default_nettype wire

// ===== sv/printf_integer_field_formatter.sv =====
// ---------------------------------------------------------------------------
// printf_integer_field_formatter
// formats one parsed printf integer conversion into a stream of characters
// ---------------------------------------------------------------------------
// an item enters the front, which cuts the value to size, takes its
// magnitude and settles the sign or hex prefix; the octal prefix is left
// to the back. the item then waits in a two-entry queue. the back loads
// the item while idle; decimal items then turn the binary magnitude into
// bcd. digits are next peeled one per cycle (up to 22 for octal, 20 for
// decimal, 16 for hex, none for zero), and the field is then sized.
// characters then go out one per cycle while the sink is ready, with last
// on the final one; each empty segment of the field is skipped in a step
// of its own, and a last step finishes. sink stalls hold up the emission.
// the front takes up to three further items (its register and the queue)
// while the back is still busy. an empty field yields no item at the output.
`default_nettype none
module printf_integer_field_formatter #(
	parameter int unsigned MAX_WIDTH     = 64,
	parameter int unsigned MAX_PRECISION = 40
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pfmt_if.sink      in_ch,
	pfmt_if.source    out_ch
);
	import pfmt_pkg::*;

	pfmt_job_t f_job, q_job;
	logic      f_valid, f_ready, q_valid, q_ready;
	pfmt_out_t o_data;

	// front: classify and size the item
	pfmt_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_PRECISION(MAX_PRECISION)) u_front (
		.clk, .arst_n,
		.in_data(in_ch.data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.job(f_job), .job_valid(f_valid), .job_ready(f_ready)
	);

	// short queue decoupling the two halves
	pfmt_fifo u_fifo (
		.clk, .arst_n,
		.wr_data(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_data(q_job), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	// back: digit conversion and character emission
	pfmt_back u_back (
		.clk, .arst_n,
		.job(q_job), .job_valid(q_valid), .job_ready(q_ready),
		.out_data(o_data), .out_valid(out_ch.valid), .out_ready(out_ch.ready)
	);

	assign out_ch.data = o_data;
endmodule
`default_nettype wire

// ===== sv/pfmt_checker.sv =====
// ---------------------------------------------------------------------------
// pfmt_checker
// port-level checks on the formatter
// ---------------------------------------------------------------------------
`default_nettype none
module pfmt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [7:0] out_char,
	input wire logic out_last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("output changed while stalled");
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_char[7])
		else $error("non-ascii character");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_last))
		else $error("unknown last flag");
endmodule

bind printf_integer_field_formatter pfmt_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_char(out_ch.data.character), .out_last(out_ch.data.last)
);
`default_nettype wire

// ===== test/printf_integer_field_formatter_tb.sv =====
// ---------------------------------------------------------------------------
// printf_integer_field_formatter_tb
// drives parsed integer conversions into the formatter and checks every
// character of each field against a local model of the printf rules
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module printf_integer_field_formatter_tb;
	import pfmt_pkg::*;

	localparam int unsigned FMT_MAX_WIDTH = 64;
	localparam int unsigned FMT_MAX_PREC  = 40;
	localparam int unsigned CYCLE_LIMIT   = 2000000;
	localparam int unsigned DRAIN_CYCLES  = 200;

	logic clk;
	logic arst_n;

	pfmt_if #(.payload_t(pfmt_in_t))  in_ch ();
	pfmt_if #(.payload_t(pfmt_out_t)) out_ch ();

	printf_integer_field_formatter #(
		.MAX_WIDTH(FMT_MAX_WIDTH),
		.MAX_PRECISION(FMT_MAX_PREC)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// pending conversions and expected characters
	pfmt_in_t  conv_queue[$];
	pfmt_out_t char_queue[$];
	int unsigned error_count;
	int unsigned cycle_count;
	logic hold_sender;
	logic in_taken;

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// builds the expected field for one conversion and queues its characters
	task automatic format_field(input pfmt_in_t c);
		logic [2:0]  conv;
		int unsigned bits, base, prec, width, nd, zeros, plen, flen, pad, i, d;
		logic [63:0] mask, mag, m;
		logic        neg, left, zpad, blank, upper;
		logic [7:0]  digs[24];
		logic [7:0]  pre[2];
		logic [7:0]  fld[$];
		pfmt_out_t   r;
		conv  = c.conv_type;
		left  = c.left_align;
		zpad  = c.zero_pad && !left;
		blank = c.blank_sign && !c.force_plus;
		width = c.field_width;
		prec  = c.digit_precision;
		neg   = 1'b0;
		nd    = 0;
		plen  = 0;
		// unknown types behave as unsigned decimal
		if (conv > CONV_PTR) conv = CONV_UDEC;
		if (width > FMT_MAX_WIDTH) width = FMT_MAX_WIDTH;
		if (conv == CONV_PTR) begin
			bits = 64;
			prec = PTR_PREC;
		end else begin
			bits = 8 << c.size_code;
			if (!c.precision_given) prec = 1;
			else if (prec > FMT_MAX_PREC) prec = FMT_MAX_PREC;
		end
		mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
		mag = c.value & mask;
		if (conv == CONV_SDEC && mag[bits-1]) begin
			neg = 1'b1;
			mag = (~mag + 64'd1) & mask;
		end
		if (conv <= CONV_UDEC) base = 10;
		else if (conv == CONV_OCT) base = 8;
		else base = 16;
		upper = (conv != CONV_HEXL);
		m = mag;
		while (m != 0) begin
			d = 32'(m % base);
			digs[nd] = (d < 10) ? 8'(8'h30 + d)
				: (upper ? 8'(8'h37 + d) : 8'(8'h57 + d));
			nd++;
			m = m / base;
		end
		zeros = (prec > nd) ? prec - nd : 0;
		if (conv == CONV_SDEC) begin
			if (neg) pre[plen++] = "-";
			else if (c.force_plus) pre[plen++] = "+";
			else if (blank) pre[plen++] = " ";
		end else if (c.alt_form && conv == CONV_OCT) begin
			// octal prefix only when no precision zero already leads
			if (zeros == 0) pre[plen++] = "0";
		end else if (c.alt_form && conv >= CONV_HEXL && mag != 0) begin
			pre[plen++] = "0";
			pre[plen++] = upper ? "X" : "x";
		end
		flen = plen + zeros + nd;
		pad = (width > flen) ? width - flen : 0;
		if (!left && !zpad) for (i = 0; i < pad; i++) fld.push_back(" ");
		for (i = 0; i < plen; i++) fld.push_back(pre[i]);
		if (!left && zpad) for (i = 0; i < pad; i++) fld.push_back("0");
		for (i = 0; i < zeros; i++) fld.push_back("0");
		for (i = nd; i > 0; i--) fld.push_back(digs[i-1]);
		if (left) for (i = 0; i < pad; i++) fld.push_back(" ");
		while (fld.size() > MAX_OUT) void'(fld.pop_back());
		foreach (fld[k]) begin
			r.character = fld[k];
			r.last = (k == fld.size() - 1);
			char_queue.push_back(r);
		end
	endtask

	function automatic pfmt_in_t random_conv();
		pfmt_in_t c;
		c.conv_type = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		c.size_code = 2'($urandom);
		c.left_align = 1'($urandom);
		c.force_plus = 1'($urandom);
		c.zero_pad = 1'($urandom);
		c.blank_sign = 1'($urandom);
		c.alt_form = 1'($urandom);
		// mostly short fields, sometimes wide or over the cap
		case ($urandom_range(0, 7))
			0: c.field_width = 7'($urandom);
			1: c.field_width = 7'($urandom_range(30, 64));
			default: c.field_width = 7'($urandom_range(0, 12));
		endcase
		c.precision_given = 1'($urandom);
		c.digit_precision = ($urandom_range(0, 5) == 0) ? 6'($urandom)
			: 6'($urandom_range(0, 6));
		case ($urandom_range(0, 5))
			0: c.value = 64'($urandom_range(0, 3));
			1: c.value = '1;
			2: c.value = {$urandom, $urandom} >> $urandom_range(0, 63);
			default: c.value = {$urandom, $urandom};
		endcase
		return c;
	endfunction

	function automatic pfmt_in_t make_conv(input logic [2:0] t, input logic [1:0] sz,
			input logic [4:0] flags, input logic [6:0] w, input logic pg,
			input logic [5:0] p, input logic [63:0] v);
		pfmt_in_t c;
		c.conv_type = t;
		c.size_code = sz;
		{c.left_align, c.force_plus, c.zero_pad, c.blank_sign, c.alt_form} = flags;
		c.field_width = w;
		c.precision_given = pg;
		c.digit_precision = p;
		c.value = v;
		return c;
	endfunction

	// driver: inputs change on the falling edge, with idle gaps drawn at random between items
	int unsigned send_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			send_gap = $urandom_range(0, 3);
			in_taken = 1'b0;
		end else begin
			if (in_ch.valid && !in_taken) begin
				// hold the item until it is taken
			end else if (hold_sender || conv_queue.size() == 0) begin
				in_ch.valid <= 1'b0;
			end else if (send_gap != 0) begin
				in_ch.valid <= 1'b0;
				send_gap--;
			end else begin
				in_ch.valid <= 1'b1;
				in_ch.data <= conv_queue[0];
				send_gap = $urandom_range(0, 3);
			end
			in_taken = 1'b0;
		end
	end

	// acceptance is seen at the rising edge; the prediction is queued then
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			format_field(in_ch.data);
			void'(conv_queue.pop_front());
			in_taken = 1'b1;
		end
	end

	// sink ready: a stall of random length drawn per character
	int unsigned stall_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (out_ch.ready && out_ch.valid) begin
			stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
			out_ch.ready <= (stall_left == 0);
		end else if (stall_left != 0) begin
			stall_left--;
			out_ch.ready <= (stall_left == 0);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// monitor: compare each character with the oldest expectation
	always @(posedge clk) begin
		pfmt_out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (char_queue.size() == 0) begin
				report($sformatf("unexpected character %h", out_ch.data.character));
			end else begin
				want = char_queue.pop_front();
				if (out_ch.data.character !== want.character)
					report($sformatf("character got %h want %h",
						out_ch.data.character, want.character));
				if (out_ch.data.last !== want.last)
					report($sformatf("last got %b want %b",
						out_ch.data.last, want.last));
			end
		end
	end

	// watchdog on the cycle count
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("printf_integer_field_formatter_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		error_count = 0;
		cycle_count = 0;
		hold_sender = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every type, size extremes and the special cases
		conv_queue.push_back(make_conv(CONV_SDEC, 2'd0, 5'b00000, 7'd0, 1'b0, 6'd0, 64'h80));
		conv_queue.push_back(make_conv(CONV_SDEC, 2'd3, 5'b01000, 7'd0, 1'b0, 6'd0, 64'd0));
		conv_queue.push_back(make_conv(CONV_SDEC, 2'd1, 5'b00010, 7'd8, 1'b0, 6'd0, 64'd42));
		conv_queue.push_back(make_conv(CONV_SDEC, 2'd3, 5'b01110, 7'd30, 1'b0, 6'd0,
			64'h8000_0000_0000_0000));
		conv_queue.push_back(make_conv(CONV_UDEC, 2'd3, 5'b00000, 7'd0, 1'b0, 6'd0, '1));
		conv_queue.push_back(make_conv(CONV_UDEC, 2'd0, 5'b00000, 7'd0, 1'b0, 6'd0, 64'hFFFF));
		conv_queue.push_back(make_conv(CONV_OCT, 2'd3, 5'b00001, 7'd0, 1'b0, 6'd0, '1));
		conv_queue.push_back(make_conv(CONV_OCT, 2'd2, 5'b00001, 7'd0, 1'b1, 6'd0, 64'd0));
		conv_queue.push_back(make_conv(CONV_OCT, 2'd2, 5'b00001, 7'd0, 1'b1, 6'd5, 64'd8));
		conv_queue.push_back(make_conv(CONV_HEXL, 2'd3, 5'b00101, 7'd20, 1'b0, 6'd0,
			64'hDEAD_BEEF));
		conv_queue.push_back(make_conv(CONV_HEXU, 2'd1, 5'b00001, 7'd6, 1'b0, 6'd0, 64'd0));
		conv_queue.push_back(make_conv(CONV_HEXU, 2'd2, 5'b10001, 7'd12, 1'b1, 6'd3,
			64'hAB));
		conv_queue.push_back(make_conv(CONV_PTR, 2'd0, 5'b00000, 7'd0, 1'b1, 6'd2,
			64'h1234));
		conv_queue.push_back(make_conv(3'd6, 2'd2, 5'b01010, 7'd0, 1'b0, 6'd0, 64'hFFFF_FFFF));
		conv_queue.push_back(make_conv(3'd7, 2'd0, 5'b00000, 7'd3, 1'b0, 6'd0, 64'h1FF));
		conv_queue.push_back(make_conv(CONV_UDEC, 2'd0, 5'b00000, 7'd127, 1'b0, 6'd0, 64'd5));
		conv_queue.push_back(make_conv(CONV_UDEC, 2'd3, 5'b00100, 7'd64, 1'b1, 6'd63, '1));
		conv_queue.push_back(make_conv(CONV_SDEC, 2'd3, 5'b00000, 7'd0, 1'b1, 6'd0, 64'd0));
		conv_queue.push_back(make_conv(CONV_UDEC, 2'd2, 5'b00000, 7'd0, 1'b1, 6'd0, 64'd0));
		conv_queue.push_back(make_conv(CONV_SDEC, 2'd1, 5'b00100, 7'd10, 1'b1, 6'd4,
			64'hFFF0));
		conv_queue.push_back(make_conv(CONV_HEXL, 2'd3, 5'b11111, 7'd64, 1'b1, 6'd40, '1));

		// random part, with one pause mid-way until the output has drained
		for (n = 0; n < 380; n++) begin
			conv_queue.push_back(random_conv());
			if (n == 190) begin
				wait (conv_queue.size() == 0);
				hold_sender = 1'b1;
				wait (char_queue.size() == 0);
				repeat (DRAIN_CYCLES) @(posedge clk);
				hold_sender = 1'b0;
			end
		end

		wait (conv_queue.size() == 0);
		wait (char_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("printf_integer_field_formatter_tb OK");
		else
			$display("printf_integer_field_formatter_tb NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
